FILE: sv/fbfs_pkg.sv
package fbfs_pkg;

    // Table depth and field widths.
    localparam int NUM_ENTRIES = 16;
    localparam int INDEX_W     = 4;
    localparam int SIZE_W      = 32;
    localparam int ID_W        = 16;
    localparam int MODE_W      = 2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Fit mode codes; the unused code behaves as first fit.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Contents of one table slot.
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
    } slot_t;

    // A query as it travels along the chain, with the best pick so far.
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] req;
        logic              have;
        logic [SIZE_W-1:0] pick_size;
        logic [ID_W-1:0]   pick_id;
    } token_t;

endpackage

FILE: sv/fbfs_if.sv
interface fbfs_cmd_if
    import fbfs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [INDEX_W-1:0]   entry_index;
    logic                 entry_valid;
    logic [SIZE_W-1:0]    entry_size;
    logic [ID_W-1:0]      entry_id;
    logic [SIZE_W-1:0]    request_size;

    modport source (
        output valid, command, entry_index, entry_valid, entry_size, entry_id,
               request_size,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, entry_valid, entry_size, entry_id,
               request_size,
        output ready
    );
endinterface

interface fbfs_rsp_if
    import fbfs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ID_W-1:0]   block_id;

    modport source (
        output valid, found, block_id,
        input  ready
    );

    modport sink (
        input  valid, found, block_id,
        output ready
    );
endinterface

FILE: sv/fbfs_cell.sv
module fbfs_cell
    import fbfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [MODE_W-1:0] mode,
    input  logic              wr_en,
    input  slot_t             wr_slot,
    input  token_t            tok_prev,
    output token_t            tok_next
);

    slot_t  slot_reg;
    token_t tok_reg;
    token_t tok_next_val;
    logic   fits;
    logic   take;

    // Compare this slot against the query and keep the better candidate.
    always_comb
    begin
        fits = slot_reg.valid && (slot_reg.size >= tok_prev.req);
        take = 1'b0;
        if (fits)
        begin
            if (!tok_prev.have)
            begin
                take = 1'b1;
            end
            else if (mode == MODE_BEST)
            begin
                take = slot_reg.size < tok_prev.pick_size;
            end
            else if (mode == MODE_WORST)
            begin
                take = slot_reg.size > tok_prev.pick_size;
            end
        end
        tok_next_val = tok_prev;
        if (take)
        begin
            tok_next_val.have      = 1'b1;
            tok_next_val.pick_size = slot_reg.size;
            tok_next_val.pick_id   = slot_reg.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_reg <= wr_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next_val;
        end
    end

    assign tok_next = tok_reg;

endmodule

FILE: sv/free_block_fit_search.sv
// Free block fit search. The block holds a table of NUM_ENTRIES free-block
// slots, one per cell in a chain, where a lower index stands earlier in the
// free list. A write transaction (command 0) stores valid, size and id into
// the slot named by entry_index and gives no result; the index is INDEX_W
// bits wide, so every value names a slot. A query transaction (command 1)
// enters the first cell and moves one cell per cycle while the chain is not
// held, each cell comparing its slot against the request and keeping the
// better candidate under the selected fit mode (first, best or worst fit,
// ties to the lowest index). The block can accept its next transaction once
// the query has left the cell chain and landed in the output register;
// the result sits in that output register, so a following write or query
// may be accepted while the result waits. The chain is held only when a
// query reaches the last cell while the previous result is still waiting
// to be taken. The fit_mode register is written through fit_mode_we and
// fit_mode_wdata and must only change while the block is idle. All slots
// read as empty after reset.
module free_block_fit_search
    import fbfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fit_mode_we,
    input  logic [MODE_W-1:0] fit_mode_wdata,
    fbfs_cmd_if.sink          command_ch,
    fbfs_rsp_if.source        result_ch
);

    logic [MODE_W-1:0] fit_mode_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    logic [ID_W-1:0]   block_id_reg;

    logic   accept;
    logic   advance;
    logic   finish;
    slot_t  wr_slot;
    token_t tok [NUM_ENTRIES+1];

    // The block takes one transaction at a time; a query keeps it busy until
    // its token has left the last cell and landed in the output register.
    assign command_ch.ready = !busy_reg;
    assign accept           = command_ch.valid && !busy_reg;

    // The chain holds still only when a query sits in the last cell and its
    // result has nowhere to go; otherwise a newly accepted query moves on.
    assign advance = !tok[NUM_ENTRIES].valid || !out_valid_reg || result_ch.ready;
    assign finish  = tok[NUM_ENTRIES].valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= MODE_FIRST;
        end
        else if (fit_mode_we)
        begin
            fit_mode_reg <= fit_mode_wdata;
        end
    end

    // Data written into the addressed slot.
    always_comb
    begin
        wr_slot.valid = command_ch.entry_valid;
        wr_slot.size  = command_ch.entry_size;
        wr_slot.id    = command_ch.entry_id;
    end

    // A query starts with no candidate.
    always_comb
    begin
        tok[0].valid     = accept && (command_ch.command == CMD_QUERY);
        tok[0].req       = command_ch.request_size;
        tok[0].have      = 1'b0;
        tok[0].pick_size = '0;
        tok[0].pick_id   = '0;
    end

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        logic wr_en;

        assign wr_en = accept && (command_ch.command == CMD_WRITE)
                       && (32'(command_ch.entry_index) == i);

        fbfs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .mode     (fit_mode_reg),
            .wr_en    (wr_en),
            .wr_slot  (wr_slot),
            .tok_prev (tok[i]),
            .tok_next (tok[i+1])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept && (command_ch.command == CMD_QUERY))
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The id reads as zero when nothing fits.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            found_reg    <= tok[NUM_ENTRIES].have;
            block_id_reg <= tok[NUM_ENTRIES].have ? tok[NUM_ENTRIES].pick_id : '0;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.found    = found_reg;
    assign result_ch.block_id = block_id_reg;

endmodule
